/* hdl/asc_pkg.sv */
package asc_pkg;

  // Pipeline depths of the two iterative units; one result bit per stage.
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef logic signed [31:0] coord_t;
  typedef logic [30:0] mag_t;

  typedef enum logic [1:0] {
    KIND_MISS,
    KIND_INSIDE,
    KIND_OUTSIDE
  } kind_t;

  typedef struct packed {
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [31:0] box_center_z;
    logic [30:0] box_half_x;
    logic [30:0] box_half_y;
    logic [30:0] box_half_z;
    logic signed [31:0] sphere_center_x;
    logic signed [31:0] sphere_center_y;
    logic signed [31:0] sphere_center_z;
    logic [30:0] sphere_radius;
    logic swap_points;
  } in_item_t;

  typedef struct packed {
    logic contact;
    logic center_inside;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
  } out_item_t;

  // Classified job handed from the front end to the back end. For an inside
  // job pa and pb are final; for an outside job pa is final and pb holds the
  // sphere center, from which the scaled offset is still to be taken.
  typedef struct packed {
    kind_t kind;
    logic swap;
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    logic [2:0][30:0] mag;
    logic [2:0] neg;
    mag_t rad;
  } ctx_t;

  function automatic coord_t sat34(input logic signed [33:0] v);
    coord_t r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/asc_front.sv */
module asc_front import asc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     push,
  output logic     full,
  output ctx_t     job,
  output logic     job_valid,
  input  logic     job_full
);

  logic adv;
  logic v1, v2;
  in_item_t in1, in2;
  logic signed [32:0] p1 [3];
  logic signed [31:0] t2 [3];
  logic [30:0] fd2 [3];
  logic [30:0] mag2 [3];
  logic [2:0] neg2, tpos2;
  logic miss2, border2;

  // Per-axis views of the incoming item and of the stored items.
  logic signed [31:0] bc0 [3], sc0 [3], bc2 [3], sc2 [3];
  logic [30:0] h1 [3];

  logic signed [31:0] t_c [3];
  logic [30:0] fd_c [3], mag_c [3];
  logic [2:0] neg_c, tpos_c, over_c, bord_c;

  assign adv = !v2 || !job_full;
  assign full = !adv;
  assign job_valid = v2;

  always_comb begin
    bc0[0] = in_item.box_center_x;
    bc0[1] = in_item.box_center_y;
    bc0[2] = in_item.box_center_z;
    sc0[0] = in_item.sphere_center_x;
    sc0[1] = in_item.sphere_center_y;
    sc0[2] = in_item.sphere_center_z;
    h1[0] = in1.box_half_x;
    h1[1] = in1.box_half_y;
    h1[2] = in1.box_half_z;
    bc2[0] = in2.box_center_x;
    bc2[1] = in2.box_center_y;
    bc2[2] = in2.box_center_z;
    sc2[0] = in2.sphere_center_x;
    sc2[1] = in2.sphere_center_y;
    sc2[2] = in2.sphere_center_z;
  end

  // Stage one: relative sphere center.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in1 <= in_item;
      for (int i = 0; i < 3; i++) begin
        p1[i] <= $signed({sc0[i][31], sc0[i]}) - $signed({bc0[i][31], bc0[i]});
      end
    end
  end

  // Stage two: clamp to the box, offset from the clamped point, face distance.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [33:0] hx, pe, tt, dd, ad, at;
      hx = $signed({3'b000, h1[i]});
      pe = $signed({p1[i][32], p1[i]});
      tt = pe;
      bord_c[i] = 1'b0;
      if (pe < -hx) begin
        tt = -hx;
        bord_c[i] = 1'b1;
      end
      if (pe > hx) begin
        tt = hx;
        bord_c[i] = 1'b1;
      end
      dd = pe - tt;
      ad = dd[33] ? -dd : dd;
      at = tt[33] ? -tt : tt;
      t_c[i] = tt[31:0];
      tpos_c[i] = !tt[33] && (tt != 34'sd0);
      neg_c[i] = dd[33];
      over_c[i] = ad > $signed({3'b000, in1.sphere_radius});
      mag_c[i] = ad[30:0];
      fd_c[i] = 31'(hx - at);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in2 <= in1;
      t2 <= t_c;
      fd2 <= fd_c;
      mag2 <= mag_c;
      neg2 <= neg_c;
      tpos2 <= tpos_c;
      miss2 <= |over_c;
      border2 <= |bord_c;
    end
  end

  // Classification: inside jobs are finished here, outside jobs are prepared.
  always_comb begin
    logic [1:0] ax;
    logic [30:0] best;
    logic signed [33:0] sce, bst, rde;
    ax = 2'd0;
    best = fd2[0];
    sce = '0;
    bst = '0;
    rde = '0;
    if (fd2[1] < best) begin
      ax = 2'd1;
      best = fd2[1];
    end
    if (fd2[2] < best) begin
      ax = 2'd2;
      best = fd2[2];
    end
    job.swap = in2.swap_points;
    job.rad = in2.sphere_radius;
    job.neg = neg2;
    for (int i = 0; i < 3; i++) begin
      job.mag[i] = mag2[i];
    end
    if (!border2) begin
      job.kind = KIND_INSIDE;
      for (int i = 0; i < 3; i++) begin
        job.pa[i] = sc2[i];
        job.pb[i] = sc2[i];
      end
      sce = $signed({{2{sc2[ax][31]}}, sc2[ax]});
      bst = $signed({3'b000, best});
      rde = $signed({3'b000, in2.sphere_radius});
      job.pa[ax] = tpos2[ax] ? sat34(sce + bst) : sat34(sce - bst);
      job.pb[ax] = tpos2[ax] ? sat34(sce - rde) : sat34(sce + rde);
    end else begin
      job.kind = miss2 ? KIND_MISS : KIND_OUTSIDE;
      for (int i = 0; i < 3; i++) begin
        job.pa[i] = sat34($signed({{2{bc2[i][31]}}, bc2[i]}) +
                          $signed({{2{t2[i][31]}}, t2[i]}));
        job.pb[i] = sc2[i];
      end
    end
  end

endmodule

/* hdl/asc_queue.sv */
module asc_queue import asc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ctx_t wr_data,
  output logic full,
  input  logic pop,
  output ctx_t rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ctx_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/asc_sqrt.sv */
module asc_sqrt import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [61:0] in_value,
  input  ctx_t        in_ctx,
  output logic        out_valid,
  output logic [30:0] out_root,
  output ctx_t        out_ctx
);

  logic v [SQRT_STAGES];
  logic [32:0] rem [SQRT_STAGES];
  logic [30:0] root [SQRT_STAGES];
  logic [61:0] rest [SQRT_STAGES];
  ctx_t ctx [SQRT_STAGES];

  // Digit-by-digit square root, two radicand bits and one root bit per stage.
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic vi;
    logic [32:0] rem_i;
    logic [30:0] root_i;
    logic [61:0] rest_i;
    ctx_t ctx_i;
    logic [34:0] acc, trial;
    logic ge;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign rem_i = '0;
      assign root_i = '0;
      assign rest_i = in_value;
      assign ctx_i = in_ctx;
    end else begin : g_next
      assign vi = v[k-1];
      assign rem_i = rem[k-1];
      assign root_i = root[k-1];
      assign rest_i = rest[k-1];
      assign ctx_i = ctx[k-1];
    end

    assign acc = {rem_i, rest_i[61:60]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 33'(acc - trial) : acc[32:0];
        root[k] <= {root_i[29:0], ge};
        rest[k] <= {rest_i[59:0], 2'b00};
        ctx[k] <= ctx_i;
      end
    end
  end

  assign out_valid = v[SQRT_STAGES-1];
  assign out_root = root[SQRT_STAGES-1];
  assign out_ctx = ctx[SQRT_STAGES-1];

endmodule

/* hdl/asc_div.sv */
module asc_div import asc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][63:0] in_numer,
  input  logic [31:0]      in_den,
  input  ctx_t             in_ctx,
  output logic             out_valid,
  output logic [2:0][31:0] out_quot,
  output ctx_t             out_ctx
);

  logic v [DIV_STAGES];
  logic [2:0][31:0] rem [DIV_STAGES];
  logic [2:0][31:0] lq [DIV_STAGES];
  logic [31:0] den [DIV_STAGES];
  ctx_t ctx [DIV_STAGES];

  // Restoring division, three lanes sharing one divisor. The low dividend
  // bits shift out of lq as the quotient bits shift in.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic vi;
    logic [2:0][31:0] rem_i, lq_i;
    logic [31:0] den_i;
    ctx_t ctx_i;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign den_i = in_den;
      assign ctx_i = in_ctx;
      for (genvar l = 0; l < 3; l++) begin : g_ld
        assign rem_i[l] = in_numer[l][63:32];
        assign lq_i[l] = in_numer[l][31:0];
      end
    end else begin : g_next
      assign vi = v[k-1];
      assign rem_i = rem[k-1];
      assign lq_i = lq[k-1];
      assign den_i = den[k-1];
      assign ctx_i = ctx[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          logic [32:0] acc;
          logic ge;
          acc = {rem_i[l], lq_i[l][31]};
          ge = acc >= {1'b0, den_i};
          rem[k][l] <= ge ? 32'(acc - {1'b0, den_i}) : acc[31:0];
          lq[k][l] <= {lq_i[l][30:0], ge};
        end
        den[k] <= den_i;
        ctx[k] <= ctx_i;
      end
    end
  end

  assign out_valid = v[DIV_STAGES-1];
  assign out_quot = lq[DIV_STAGES-1];
  assign out_ctx = ctx[DIV_STAGES-1];

endmodule

/* hdl/asc_back.sv */
module asc_back import asc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctx_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  logic en;
  logic out_valid;

  logic v0, v1, v2, v3, v4;
  ctx_t ctx0, ctx1, ctx2, ctx3, ctx4;
  ctx_t ctx1_chk;
  logic [61:0] sq0 [3];
  logic [61:0] r2_0, r2_1;
  logic [63:0] sum1;
  logic [61:0] sum2;
  logic [61:0] prod3 [3];
  logic [30:0] len3;
  logic [2:0][63:0] numer4;
  logic [31:0] den4;

  logic sq_valid;
  logic [30:0] sq_root;
  ctx_t sq_ctx;
  logic dv_valid;
  logic [2:0][31:0] dv_quot;
  ctx_t dv_ctx;
  out_item_t res_c;

  // The whole back end moves in lockstep; it holds only while a finished
  // result waits on the ports and is not taken.
  assign en = !out_valid || pop;
  assign job_pop = en && !job_empty;
  assign empty = !out_valid;

  // Exact distance test against the radius.
  always_comb begin
    ctx1_chk = ctx1;
    if (ctx1.kind == KIND_OUTSIDE && sum1 > 64'(r2_1)) begin
      ctx1_chk.kind = KIND_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= !job_empty;
      v1 <= v0;
      v2 <= v1;
      v3 <= sq_valid;
      v4 <= v3;
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Squares of the offsets and of the radius.
      ctx0 <= job;
      for (int i = 0; i < 3; i++) begin
        sq0[i] <= 62'(job.mag[i]) * 62'(job.mag[i]);
      end
      r2_0 <= 62'(job.rad) * 62'(job.rad);

      ctx1 <= ctx0;
      sum1 <= 64'(sq0[0]) + 64'(sq0[1]) + 64'(sq0[2]);
      r2_1 <= r2_0;

      ctx2 <= ctx1_chk;
      sum2 <= sum1[61:0];

      // Offset times radius, and the length floored at one.
      ctx3 <= sq_ctx;
      for (int i = 0; i < 3; i++) begin
        prod3[i] <= 62'(sq_ctx.mag[i]) * 62'(sq_ctx.rad);
      end
      len3 <= (sq_root == '0) ? 31'd1 : sq_root;

      // Round to nearest: (2*a*r + len) / (2*len).
      ctx4 <= ctx3;
      for (int i = 0; i < 3; i++) begin
        numer4[i] <= {1'b0, prod3[i], 1'b0} + 64'(len3);
      end
      den4 <= {len3, 1'b0};

      result <= res_c;
    end
  end

  asc_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v2),
    .in_value(sum2),
    .in_ctx(ctx2),
    .out_valid(sq_valid),
    .out_root(sq_root),
    .out_ctx(sq_ctx)
  );

  asc_div u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v4),
    .in_numer(numer4),
    .in_den(den4),
    .in_ctx(ctx4),
    .out_valid(dv_valid),
    .out_quot(dv_quot),
    .out_ctx(dv_ctx)
  );

  always_comb begin
    coord_t pa [3];
    coord_t pb [3];
    logic signed [33:0] sce, off;
    for (int i = 0; i < 3; i++) begin
      pa[i] = dv_ctx.pa[i];
      sce = $signed({{2{dv_ctx.pb[i][31]}}, dv_ctx.pb[i]});
      off = $signed({2'b00, dv_quot[i]});
      if (dv_ctx.kind == KIND_OUTSIDE) begin
        pb[i] = dv_ctx.neg[i] ? sat34(sce + off) : sat34(sce - off);
      end else begin
        pb[i] = dv_ctx.pb[i];
      end
      if (dv_ctx.swap) begin
        sce = $signed({{2{pa[i][31]}}, pa[i]});
        pa[i] = pb[i];
        pb[i] = sce[31:0];
      end
    end
    res_c.contact = 1'b1;
    res_c.center_inside = (dv_ctx.kind == KIND_INSIDE);
    res_c.point_a_x = pa[0];
    res_c.point_a_y = pa[1];
    res_c.point_a_z = pa[2];
    res_c.point_b_x = pb[0];
    res_c.point_b_y = pb[1];
    res_c.point_b_z = pb[2];
    if (dv_ctx.kind == KIND_MISS) begin
      res_c = '0;
    end
  end

endmodule

/* hdl/aabb_sphere_contact_unit.sv */
// Box-sphere contact unit. Throughput is one beat per cycle in and out while the
// result side keeps popping. Between the edge that accepts an input beat and
// the first edge that can pop its result lie, when nothing stalls, 2 front
// stages, the queue, 3 setup stages, a 31-stage square root, 2 scaling stages,
// a 32-stage divider and the output register.
// Synchronous active-high reset empties the front stages, the queue and the
// back pipeline; no result is shown until a new beat has gone through.
module aabb_sphere_contact_unit import asc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  // The front end computes the relative center and the clamped point, and
  // decides whether the center is inside the box. Inside results are fully
  // formed there; outside cases that already fail the per-axis radius test
  // are marked as misses. Every job, whatever its kind, goes through the
  // back end so that results leave in arrival order.
  ctx_t front_job;
  logic front_valid;
  logic q_full;
  logic q_empty;
  logic q_pop;
  ctx_t q_job;

  asc_front u_front (
    .clk(clk),
    .rst(rst),
    .in_item(in_item),
    .push(push),
    .full(full),
    .job(front_job),
    .job_valid(front_valid),
    .job_full(q_full)
  );

  // The short queue decouples the two halves, so input beats keep flowing
  // for a while after the result side stops popping.
  asc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(front_valid),
    .wr_data(front_job),
    .full(q_full),
    .pop(q_pop),
    .rd_data(q_job),
    .empty(q_empty)
  );

  // The back end does the exact squared-distance test, the pipelined
  // square root of the squared offset, and the rounded division that scales
  // the offset to the radius. Its last register is the result port.
  asc_back u_back (
    .clk(clk),
    .rst(rst),
    .job(q_job),
    .job_empty(q_empty),
    .job_pop(q_pop),
    .result(out_item),
    .empty(empty),
    .pop(pop)
  );

endmodule

/* tb/asc_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the contact unit, predicts each result from the
// accepted input beat and compares it field by field with what comes out.
module asc_checker import asc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  input  logic      full,
  input  out_item_t out_item,
  input  logic      empty,
  input  logic      pop,
  output int        errors,
  output int        waiting
);

  out_item_t contact_q[$];

  function automatic coord_t clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t predict_contact(input in_item_t it);
    longint bc[3], sc[3], h[3], p[3], t[3], pa[3], pb[3], d[3];
    longint rad, best, fd, sgn, off;
    longint unsigned a, sum, r2, len, q;
    bit border;
    int ax;
    out_item_t r;
    r = '0;
    border = 0;
    rad = longint'({1'b0, it.sphere_radius});
    bc[0] = longint'(it.box_center_x);
    bc[1] = longint'(it.box_center_y);
    bc[2] = longint'(it.box_center_z);
    sc[0] = longint'(it.sphere_center_x);
    sc[1] = longint'(it.sphere_center_y);
    sc[2] = longint'(it.sphere_center_z);
    h[0] = longint'({1'b0, it.box_half_x});
    h[1] = longint'({1'b0, it.box_half_y});
    h[2] = longint'({1'b0, it.box_half_z});
    for (int i = 0; i < 3; i++) begin
      p[i] = sc[i] - bc[i];
      t[i] = p[i];
      if (t[i] < -h[i]) begin
        t[i] = -h[i];
        border = 1;
      end
      if (t[i] > h[i]) begin
        t[i] = h[i];
        border = 1;
      end
    end
    if (!border) begin
      // Center inside: push out through the nearest face, lowest axis on ties.
      ax = 0;
      best = h[0] - ((t[0] < 0) ? -t[0] : t[0]);
      for (int i = 1; i < 3; i++) begin
        fd = h[i] - ((t[i] < 0) ? -t[i] : t[i]);
        if (fd < best) begin
          best = fd;
          ax = i;
        end
      end
      sgn = (t[ax] > 0) ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
        pa[i] = sc[i];
        pb[i] = sc[i];
      end
      pa[ax] = sc[ax] + sgn * best;
      pb[ax] = sc[ax] - sgn * rad;
      r.center_inside = 1'b1;
    end else begin
      sum = 0;
      r2 = longint'(rad) * longint'(rad);
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i] - t[i];
        a = (d[i] < 0) ? -d[i] : d[i];
        if (a > rad) return r;
        sum = sum + a * a;
      end
      if (sum > r2) return r;
      len = floor_sqrt(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        a = (d[i] < 0) ? -d[i] : d[i];
        q = (a * rad * 2 + len) / (len * 2);
        off = (d[i] < 0) ? -longint'(q) : longint'(q);
        pa[i] = bc[i] + t[i];
        pb[i] = sc[i] - off;
      end
    end
    r.contact = 1'b1;
    if (it.swap_points) begin
      {r.point_a_x, r.point_a_y, r.point_a_z} = {clip32(pb[0]), clip32(pb[1]), clip32(pb[2])};
      {r.point_b_x, r.point_b_y, r.point_b_z} = {clip32(pa[0]), clip32(pa[1]), clip32(pa[2])};
    end else begin
      {r.point_a_x, r.point_a_y, r.point_a_z} = {clip32(pa[0]), clip32(pa[1]), clip32(pa[2])};
      {r.point_b_x, r.point_b_y, r.point_b_z} = {clip32(pb[0]), clip32(pb[1]), clip32(pb[2])};
    end
    return r;
  endfunction

  assign waiting = contact_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t want;
    logic [31:0] wv[8], gv[8];
    string names[8];
    bit bad;
    if (!rst) begin
      if (push && !full) contact_q = {contact_q, predict_contact(in_item)};
      if (pop && !empty) begin
        if (contact_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = contact_q.pop_front();
          names = '{"contact", "center_inside", "point_a_x", "point_a_y", "point_a_z",
                    "point_b_x", "point_b_y", "point_b_z"};
          wv = '{want.contact, want.center_inside, want.point_a_x, want.point_a_y,
                 want.point_a_z, want.point_b_x, want.point_b_y, want.point_b_z};
          gv = '{out_item.contact, out_item.center_inside, out_item.point_a_x,
                 out_item.point_a_y, out_item.point_a_z, out_item.point_b_x,
                 out_item.point_b_y, out_item.point_b_z};
          bad = 0;
          for (int i = 0; i < 8; i++) begin
            if (wv[i] !== gv[i]) begin
              bad = 1;
              if (errors < 10)
                $display("mismatch %s: expected %h actual %h at %0t",
                         names[i], wv[i], gv[i], $realtime);
            end
          end
          if (bad) errors <= errors + 1;
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the box-sphere contact unit. The checker beside the
// block predicts and compares every result beat; this module only feeds beats,
// throttles the result side and decides pass or fail.
module tb_top;
  import asc_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  in_item_t  in_item = '0;
  logic      push = 0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop = 0;
  int        errors;
  int        waiting;

  // calm turns off idling on both sides; hold_req asks the receiver for a long
  // stall while the sender keeps offering beats.
  bit calm = 0;
  bit hold_req = 0;

  always #5 clk = ~clk;

  aabb_sphere_contact_unit u_dut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  asc_checker u_chk (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop), .errors(errors), .waiting(waiting)
  );

  // Well-formed pairs place the sphere near the box at a random scale, so all
  // three outcomes (inside, outside contact, miss) come up often. The rest is
  // full-range noise that reaches every bit of every field.
  function automatic in_item_t random_pair();
    in_item_t it;
    int sc;
    logic [31:0] span;
    logic [319:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 9) < 8) begin
      sc = $urandom_range(1, 29);
      span = 32'd1 << sc;
      it.box_half_x = 31'($urandom_range(0, span));
      it.box_half_y = 31'($urandom_range(0, span));
      it.box_half_z = 31'($urandom_range(0, span));
      it.sphere_radius = 31'($urandom_range(0, span));
      if ($urandom_range(0, 7) == 0) it.box_half_y = 0;
      it.sphere_center_x = it.box_center_x + $signed($urandom_range(0, 4 * span)) - 2 * span;
      it.sphere_center_y = it.box_center_y + $signed($urandom_range(0, 4 * span)) - 2 * span;
      it.sphere_center_z = it.box_center_z + $signed($urandom_range(0, 4 * span)) - 2 * span;
      if ($urandom_range(0, 15) == 0) it.sphere_center_y = it.box_center_y;
    end
    return it;
  endfunction

  function automatic in_item_t make_pair(input int bx, by, bz,
                                         input int hx, hy, hz,
                                         input int sx, sy, sz,
                                         input int rad, input int swp);
    in_item_t it;
    it = '{bx, by, bz, 31'(hx), 31'(hy), 31'(hz), sx, sy, sz, 31'(rad), swp[0]};
    return it;
  endfunction

  // Offers one beat and returns once it is accepted. The gap before the beat
  // is chosen here so push is written only once per edge.
  task automatic send_pair(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < 26) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 26);
    end
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // Result side: random pop with idling, or a long counted stall on request.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
        @(posedge clk);
      end
    end
  end

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam int UMAX = 2147483647;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Center inside, nearest face on x, then ties resolved to the lowest axis.
    send_pair(make_pair(0, 0, 0, 4*ONE, 8*ONE, 8*ONE, 3*ONE, 1, 2, ONE, 0));
    send_pair(make_pair(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 1, 1, 1, ONE, 0));
    // Center exactly at the box center: zero coordinate gives the minus normal.
    send_pair(make_pair(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, ONE, ONE, ONE, ONE, 1));
    // Nearest face on z with a negative coordinate.
    send_pair(make_pair(0, 0, 0, 9*ONE, 9*ONE, 3*ONE, 0, 0, -2*ONE, 2*ONE, 0));
    // Outside, touching on one axis, then a corner contact, both with swap.
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, 3*ONE, 0, 0, 2*ONE, 1));
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 2*ONE, 1));
    // Miss through a single axis, and a miss only through the squared sum.
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, 5*ONE, 0, 0, 2*ONE, 0));
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, 3*ONE, 3*ONE, 0, 2*ONE, 1));
    // Zero half extents: inside only at the exact center, else outside.
    send_pair(make_pair(5, 6, 7, 0, 0, 0, 5, 6, 7, 0, 0));
    send_pair(make_pair(5, 6, 7, 0, 0, 0, 6, 6, 7, 1, 0));
    send_pair(make_pair(0, 0, 0, 0, ONE, ONE, 1, 0, 0, 0, 0));
    // Zero radius on a face.
    send_pair(make_pair(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 0, 1));
    // Extremes of every field, with saturated points.
    send_pair(make_pair(SMAX, SMAX, SMAX, UMAX, UMAX, UMAX, SMIN, SMIN, SMIN, UMAX, 0));
    send_pair(make_pair(SMIN, SMIN, SMIN, UMAX, UMAX, UMAX, SMAX, SMAX, SMAX, UMAX, 1));
    send_pair(make_pair(SMIN, SMIN, SMIN, 0, 0, 0, SMAX, SMAX, SMAX, UMAX, 0));
    send_pair(make_pair(SMAX, 0, SMIN, UMAX, 0, UMAX, SMAX, 0, SMIN, UMAX, 1));
    send_pair(make_pair(SMAX, SMAX, SMAX, 0, 0, 0, SMAX, SMAX, SMAX, UMAX, 0));
    send_pair(make_pair(SMIN, 0, 0, UMAX, 0, 0, SMAX, 0, 0, UMAX, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, SMIN, SMIN, SMIN, UMAX, 1));
    send_pair(make_pair(-1, -1, -1, UMAX, UMAX, UMAX, -1, -1, -1, 0, 0));

    for (int n = 0; n < 1250; n++) begin
      // A stretch with no idling on either side.
      if (n == 300) calm = 1;
      if (n == 500) calm = 0;
      // Long result-side stall while beats keep coming, so the block fills.
      if (n == 700) hold_req = 1;
      // Drain completely before going on.
      if (n == 1000) begin
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
      end
      send_pair(random_pair());
    end
    push <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
